// ===== rtl/core/bbpe_pkg.sv =====
// ============================================================================
// bbpe_pkg
// Shared widths, codes and types of the bicubic Bezier patch evaluator.
// ============================================================================
package bbpe_pkg;

  localparam int PARAM_FRAC_BITS = 15;
  localparam int PARAM_W         = 16;
  localparam int COORD_W         = 32;

  localparam int GRID_DIM = 4;
  localparam int GRID_N   = GRID_DIM * GRID_DIM;
  localparam int ADDR_W   = $clog2(GRID_N);
  localparam int SEL_W    = $clog2(GRID_DIM);

  // weight pipeline
  localparam int PV_W   = PARAM_FRAC_BITS + 1;
  localparam int SQ_W   = 2 * PV_W;
  localparam int CUBE_W = 3 * PV_W;
  localparam int BERN_W = CUBE_W + 2;
  localparam int WGT_W  = PARAM_FRAC_BITS + 1;
  localparam logic [PV_W-1:0]   PARAM_ONE = PV_W'(2 ** PARAM_FRAC_BITS);
  localparam logic [BERN_W-1:0] BERN_HALF = BERN_W'(2 ** (2 * PARAM_FRAC_BITS - 1));
  localparam int WGT_WAIT = 2;

  // accumulation lanes
  localparam int PROD_W  = COORD_W + WGT_W + 1;
  localparam int ACC_W   = PROD_W + SEL_W;
  localparam int ROW_W   = ACC_W - PARAM_FRAC_BITS;
  localparam int RPROD_W = ROW_W + WGT_W + 1;
  localparam int TOT_W   = RPROD_W + SEL_W;
  localparam int FIN_W   = TOT_W - PARAM_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** (PARAM_FRAC_BITS - 1));
  localparam logic signed [TOT_W-1:0] TOT_HALF = TOT_W'(2 ** (PARAM_FRAC_BITS - 1));
  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(GRID_DIM - 1);
  localparam logic [SEL_W-1:0] SEL_FIRST = '0;

  // stream layout
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 3 * COORD_W;
  localparam int IN_IDX_LSB = 0;
  localparam int IN_X_LSB   = IN_IDX_LSB + ADDR_W;
  localparam int IN_Y_LSB   = IN_X_LSB + COORD_W;
  localparam int IN_Z_LSB   = IN_Y_LSB + COORD_W;
  localparam int IN_U_LSB   = IN_Z_LSB + COORD_W;
  localparam int IN_V_LSB   = IN_U_LSB + PARAM_W;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef logic [WGT_W-1:0] wgt_t;
  typedef wgt_t [GRID_DIM-1:0] wvec_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGT,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } bbpe_state_t;

  typedef struct packed {
    logic             prod_en;
    logic [SEL_W-1:0] col_sel;
    logic             acc_en;
    logic             acc_first;
    logic             row_last;
    logic             rp_en;
    logic [SEL_W-1:0] row_sel;
    logic             tot_en;
    logic             tot_first;
    logic             tot_last;
  } bbpe_ctl_t;

endpackage

// ===== rtl/core/bicubic_bezier_patch_eval.sv =====
// ============================================================================
// bicubic_bezier_patch_eval
// Bicubic Bezier patch evaluator over a 4x4 grid of Q16.16 control points.
// ============================================================================
// Input stream (in_*): in_tuser selects the request, 0 = load, 1 = evaluate.
//   A load writes one control point into the grid memory in its transfer
//   cycle and gives no result. An evaluate takes u,v in Q1.15 (above 1.0
//   reads as 1.0) and gives one result transfer on out_*.
// Output stream (out_*): x, y, z of the patch point, saturated to 32 bits;
//   out_tuser flags that at least one coordinate was clipped.
// Sequence: an evaluate passes from its transfer through the weight
//   pipeline, a scan of the grid memory (one read and one
//   multiply-accumulate per coordinate lane each cycle), the accumulate
//   drain and the load of the result register. in_tready is high only
//   between evaluations.
// Stall: a held result sits in the output register while the next request
//   is taken; a finished evaluation waits until that register is free.
// Reset: control state clears; the grid holds no defined values until each
//   slot has been loaded.
// ============================================================================
module bicubic_bezier_patch_eval (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // point_index, coord_x, coord_y, coord_z, u_param, v_param, zero pad
  input  logic [bbpe_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_x, point_y, point_z
  output logic [bbpe_pkg::OUT_DATA_W-1:0]    out_tdata,
  // saturated
  output logic                               out_tuser
);
  import bbpe_pkg::*;

  logic [OUT_DATA_W-1:0] grid_mem [GRID_N];
  logic [OUT_DATA_W-1:0] rdata_r;
  logic [PARAM_W-1:0]    u_r;
  logic [PARAM_W-1:0]    v_r;
  logic                  in_xfer;
  logic                  out_free;
  logic                  rd_en;
  addr_t                 rd_addr;
  bbpe_ctl_t             ctl;
  logic                  load_out;
  wvec_t                 wu;
  wvec_t                 wv;
  logic [COORD_W-1:0]    res [3];
  logic [2:0]            sat;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_xfer && (in_tuser == REQ_LOAD)) begin
      grid_mem[in_tdata[IN_IDX_LSB +: ADDR_W]] <= in_tdata[IN_X_LSB +: OUT_DATA_W];
    end
    if (rd_en) begin
      rdata_r <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_tuser == REQ_EVAL)) begin
      u_r <= in_tdata[IN_U_LSB +: PARAM_W];
      v_r <= in_tdata[IN_V_LSB +: PARAM_W];
    end
  end

  bbpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .out_free (out_free),
    .in_ready (in_tready),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .ctl      (ctl),
    .load_out (load_out)
  );

  bbpe_weights u_wgt_u (
    .clk (clk),
    .p   (u_r),
    .w   (wu)
  );

  bbpe_weights u_wgt_v (
    .clk (clk),
    .p   (v_r),
    .w   (wv)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    bbpe_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coord  ($signed(rdata_r[c*COORD_W +: COORD_W])),
      .bv     (wv[ctl.col_sel]),
      .bu     (wu[ctl.row_sel]),
      .result (res[c]),
      .sat    (sat[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {res[2], res[1], res[0]};
      out_tuser_r <= |sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/core/bbpe_weights.sv =====
// ============================================================================
// bbpe_weights
// Three-stage pipeline producing the four rounded Bernstein cubic weights.
// ============================================================================
module bbpe_weights (
  input  logic                           clk,
  input  logic [bbpe_pkg::PARAM_W-1:0]   p,
  output bbpe_pkg::wvec_t                w
);
  import bbpe_pkg::*;

  logic [PV_W-1:0]   pc;
  logic [PV_W-1:0]   tc;
  logic [PV_W-1:0]   pc_r;
  logic [PV_W-1:0]   t_r;
  logic [SQ_W-1:0]   pp_r;
  logic [SQ_W-1:0]   tt_r;
  logic [CUBE_W-1:0] ttt;
  logic [CUBE_W-1:0] ttp;
  logic [CUBE_W-1:0] ppt;
  logic [CUBE_W-1:0] ppp;
  logic [BERN_W-1:0] b_r [GRID_DIM];
  wvec_t             w_r;

  always_comb begin
    pc  = (p > PARAM_W'(PARAM_ONE)) ? PARAM_ONE : PV_W'(p);
    tc  = PARAM_ONE - pc;
    ttt = tt_r * t_r;
    ttp = tt_r * pc_r;
    ppt = pp_r * t_r;
    ppp = pp_r * pc_r;
  end

  always_ff @(posedge clk) begin
    pc_r <= pc;
    t_r  <= tc;
    pp_r <= pc * pc;
    tt_r <= tc * tc;
    b_r[0] <= BERN_W'(ttt);
    b_r[1] <= BERN_W'(ttp) + BERN_W'({ttp, 1'b0});
    b_r[2] <= BERN_W'(ppt) + BERN_W'({ppt, 1'b0});
    b_r[3] <= BERN_W'(ppp);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < GRID_DIM; k++) begin
      w_r[k] <= WGT_W'((b_r[k] + BERN_HALF) >> (2 * PARAM_FRAC_BITS));
    end
  end

  assign w = w_r;

endmodule

// ===== rtl/core/bbpe_lane.sv =====
// ============================================================================
// bbpe_lane
// One coordinate: row pass and column pass multiply-accumulate, then clip.
// ============================================================================
module bbpe_lane (
  input  logic                                clk,
  input  bbpe_pkg::bbpe_ctl_t                 ctl,
  input  logic signed [bbpe_pkg::COORD_W-1:0] coord,
  input  bbpe_pkg::wgt_t                      bv,
  input  bbpe_pkg::wgt_t                      bu,
  output logic        [bbpe_pkg::COORD_W-1:0] result,
  output logic                                sat
);
  import bbpe_pkg::*;

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ROW_W-1:0]   row_r;
  logic signed [RPROD_W-1:0] rprod_r;
  logic signed [TOT_W-1:0]   tot_r;
  logic signed [TOT_W-1:0]   tot_nxt;
  logic signed [FIN_W-1:0]   fin_r;
  logic [FIN_W-COORD_W:0]    hi;
  logic                      ovf;

  always_comb begin
    acc_nxt = (ctl.acc_first ? ACC_HALF : acc_r) + ACC_W'(prod_r);
    tot_nxt = (ctl.tot_first ? TOT_HALF : tot_r) + TOT_W'(rprod_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= coord * $signed({1'b0, bv});
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctl.acc_en && ctl.row_last) begin
      row_r <= ROW_W'(acc_nxt >>> PARAM_FRAC_BITS);
    end
    if (ctl.rp_en) begin
      rprod_r <= row_r * $signed({1'b0, bu});
    end
    if (ctl.tot_en) begin
      tot_r <= tot_nxt;
    end
    if (ctl.tot_en && ctl.tot_last) begin
      fin_r <= FIN_W'(tot_nxt >>> PARAM_FRAC_BITS);
    end
  end

  // clip to signed 32 bits
  always_comb begin
    hi  = fin_r[FIN_W-1:COORD_W-1];
    ovf = !((&hi) || !(|hi));
    if (ovf) begin
      result = fin_r[FIN_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      result = fin_r[COORD_W-1:0];
    end
    sat = ovf;
  end

endmodule

// ===== rtl/core/bbpe_ctrl.sv =====
// ============================================================================
// bbpe_ctrl
// Sequencer: request intake, grid memory scan and stage tags for the lanes.
// ============================================================================
module bbpe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  input  logic                out_free,
  output logic                in_ready,
  output logic                rd_en,
  output bbpe_pkg::addr_t     rd_addr,
  output bbpe_pkg::bbpe_ctl_t ctl,
  output logic                load_out
);
  import bbpe_pkg::*;

  bbpe_state_t state_r;
  bbpe_state_t state_nxt;
  addr_t       cnt_r;
  addr_t       cnt_nxt;
  logic        accept_eval;

  logic        s1_vld_r;
  addr_t       s1_idx_r;
  logic        s2_vld_r;
  addr_t       s2_idx_r;
  logic        s3_vld_r;
  logic [SEL_W-1:0] s3_i_r;
  logic        s4_vld_r;
  logic [SEL_W-1:0] s4_i_r;

  assign accept_eval = in_valid && in_ready && (in_kind == REQ_EVAL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_eval) state_nxt = ST_WGT;
      end
      ST_WGT: begin
        if (cnt_r == ADDR_W'(WGT_WAIT - 1)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == ADDR_W'(GRID_N - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (ctl.tot_en && ctl.tot_last) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    cnt_nxt = (state_nxt == state_r) ? cnt_r + 1'b1 : '0;
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    rd_en    = (state_r == ST_SCAN);
    rd_addr  = cnt_r;
    load_out = (state_r == ST_HOLD) && out_free;

    ctl.prod_en   = s1_vld_r;
    ctl.col_sel   = s1_idx_r[SEL_W-1:0];
    ctl.acc_en    = s2_vld_r;
    ctl.acc_first = (s2_idx_r[SEL_W-1:0] == SEL_FIRST);
    ctl.row_last  = (s2_idx_r[SEL_W-1:0] == SEL_LAST);
    ctl.rp_en     = s3_vld_r;
    ctl.row_sel   = s3_i_r;
    ctl.tot_en    = s4_vld_r;
    ctl.tot_first = (s4_i_r == SEL_FIRST);
    ctl.tot_last  = (s4_i_r == SEL_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && (s2_idx_r[SEL_W-1:0] == SEL_LAST);
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r;
    s2_idx_r <= s1_idx_r;
    s3_i_r   <= s2_idx_r[ADDR_W-1:SEL_W];
    s4_i_r   <= s3_i_r;
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r))
    else $error("pipeline busy while taking requests");

  a_row_tags: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({s3_vld_r, s4_vld_r}))
    else $error("row stages overlap");

  a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tot_en && ctl.tot_last |=> state_r == ST_HOLD)
    else $error("final row did not end evaluation");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && cnt_r == '0 |->
      ##15 (state_r == ST_SCAN && cnt_r == ADDR_W'(GRID_N - 1)))
    else $error("grid scan length wrong");

endmodule
